### sv/tachometer_speedometer_odometer_defines.svh
// Assertion macros shared by the tachometer RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef TACHOMETER_SPEEDOMETER_ODOMETER_DEFINES_SVH
`define TACHOMETER_SPEEDOMETER_ODOMETER_DEFINES_SVH

// Property checked in the same cycle, or with its own implication.
`define TSO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TSO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tso_pkg.sv
// Types and constants for the tachometer / speedometer / odometer block.
// No dependencies.
package tso_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [DATA_W-1:0] STOP_TIMEOUT_RST = DATA_W'(1000000);
  localparam logic [DATA_W-1:0] RPM_SCALE_RST    = DATA_W'(60000000);
  localparam logic [DATA_W-1:0] SPEED_SCALE_RST  = DATA_W'(3600000);

  typedef enum logic [1:0] {
    ACT_ENGINE = 2'd0,
    ACT_WHEEL  = 2'd1,
    ACT_REPORT = 2'd2,
    ACT_LOAD   = 2'd3
  } act_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STOP_TIMEOUT = 2'd0,
    CFG_RPM_SCALE    = 2'd1,
    CFG_SPEED_SCALE  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    act_e              action;
    logic [DATA_W-1:0] timestamp_us;
    logic [DATA_W-1:0] odometer_preset;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] rpm_value;
    logic [DATA_W-1:0] speed_value;
    logic [DATA_W-1:0] distance_m;
    logic              engine_stopped;
  } out_t;

endpackage

### sv/tso_serdiv.sv
// Bit-serial restoring divider: one quotient bit per cycle, DATA_W quotient bits.
// Depends on tso_pkg and the assertion macro header.
`include "tachometer_speedometer_odometer_defines.svh"

module tso_serdiv (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tso_pkg::DATA_W-1:0] num_i,
  input  logic [tso_pkg::DATA_W-1:0] den_i,
  output logic                       done_o,
  output logic [tso_pkg::DATA_W-1:0] quot_o
);
  import tso_pkg::*;

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] den_q;
  logic             den_zero_q;
  logic [DATA_W:0]  trial;
  logic [DATA_W:0]  diff;
  logic             fits;

  // Bring down the next numerator bit and try the subtract.
  assign trial = {rem_q, quo_q[DATA_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = ~diff[DATA_W];
  assign rem_d = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
  assign quo_d = {quo_q[DATA_W-2:0], fits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(DATA_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q      <= '0;
      quo_q      <= num_i;
      den_q      <= den_i;
      den_zero_q <= (den_i == '0);
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  // Zero divisor reads as zero quotient.
  assign quot_o = den_zero_q ? '0 : quo_q;
  assign done_o = done_q;

  `TSO_ASSERT_NEXT(a_start_busy, start_i, busy_q && !done_q, "divider did not start")
  `TSO_ASSERT(a_busy_done_excl, !(busy_q && done_q), "divider busy and done together")
  `TSO_ASSERT_NEXT(a_last_step, busy_q && !start_i && cnt_q == '0, done_q && !busy_q,
    "divider did not finish after last step")

endmodule

### sv/tachometer_speedometer_odometer.sv
// Flow: an accepted word starts both bit-serial dividers, and the result word is registered
// once both are done. The dividers give one bit per cycle; input is stalled while they run.
// A finished word sits in the output register; the next input is taken meanwhile.
// Reset: asynchronous, active low; clears sensor times, periods, metre count,
// and loads the default timeout and scale registers. No clearing pass.
`include "tachometer_speedometer_odometer_defines.svh"

module tachometer_speedometer_odometer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tso_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tso_pkg::out_t                 out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tso_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tso_pkg::DATA_W-1:0]    cfg_data_i
);
  import tso_pkg::*;

  typedef enum logic {S_IDLE, S_DIV} state_e;

  state_e            state_q;
  logic [DATA_W-1:0] timeout_q, rpm_scale_q, speed_scale_q;
  logic [DATA_W-1:0] last_eng_q, eng_period_q, last_whl_q, whl_period_q, metre_q;
  logic              stopped_q;
  logic              out_valid_q;
  out_t              out_q;

  logic              accept, load_out;
  logic [DATA_W-1:0] eng_period_d, whl_period_d, elapsed;
  logic              stopped_d;
  logic              rpm_done, spd_done;
  logic [DATA_W-1:0] rpm_quot, spd_quot;

  assign accept   = in_valid_i && !in_stall_o;
  assign load_out = (state_q == S_DIV) && rpm_done && spd_done
                    && (!out_valid_q || !out_stall_i);

  assign eng_period_d = (in_data_i.action == ACT_ENGINE) ?
                        in_data_i.timestamp_us - last_eng_q : eng_period_q;
  assign whl_period_d = (in_data_i.action == ACT_WHEEL) ?
                        in_data_i.timestamp_us - last_whl_q : whl_period_q;
  // An engine pulse resets the elapsed time to zero.
  assign elapsed   = (in_data_i.action == ACT_ENGINE) ? '0 :
                     in_data_i.timestamp_us - last_eng_q;
  assign stopped_d = elapsed > timeout_q;

  tso_serdiv u_rpm_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .num_i   (rpm_scale_q),
    .den_i   (eng_period_d),
    .done_o  (rpm_done),
    .quot_o  (rpm_quot)
  );

  tso_serdiv u_spd_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .num_i   (speed_scale_q),
    .den_i   (whl_period_d),
    .done_o  (spd_done),
    .quot_o  (spd_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      timeout_q     <= STOP_TIMEOUT_RST;
      rpm_scale_q   <= RPM_SCALE_RST;
      speed_scale_q <= SPEED_SCALE_RST;
      last_eng_q    <= '0;
      eng_period_q  <= '0;
      last_whl_q    <= '0;
      whl_period_q  <= '0;
      metre_q       <= '0;
      stopped_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_STOP_TIMEOUT: timeout_q     <= cfg_data_i;
          CFG_RPM_SCALE:    rpm_scale_q   <= cfg_data_i;
          CFG_SPEED_SCALE:  speed_scale_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (load_out) begin
        out_valid_q          <= 1'b1;
        out_q.rpm_value      <= stopped_q ? '0 : rpm_quot;
        out_q.speed_value    <= spd_quot;
        out_q.distance_m     <= metre_q;
        out_q.engine_stopped <= stopped_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q      <= S_DIV;
            stopped_q    <= stopped_d;
            eng_period_q <= eng_period_d;
            whl_period_q <= whl_period_d;
            unique case (in_data_i.action)
              ACT_ENGINE: last_eng_q <= in_data_i.timestamp_us;
              ACT_WHEEL: begin
                last_whl_q <= in_data_i.timestamp_us;
                metre_q    <= metre_q + 1'b1;
              end
              ACT_LOAD:   metre_q <= in_data_i.odometer_preset;
              ACT_REPORT: ;
            endcase
          end
        end
        S_DIV: begin
          if (load_out) begin
            state_q <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  `TSO_ASSERT_NEXT(a_accept_div, accept, state_q == S_DIV && !rpm_done,
    "accepted word did not start the dividers")
  `TSO_ASSERT(a_lanes_lockstep, rpm_done == spd_done, "divider lanes out of step")
  `TSO_ASSERT_NEXT(a_engine_running, accept && in_data_i.action == ACT_ENGINE, !stopped_q,
    "engine pulse flagged as stopped")
  `TSO_ASSERT_NEXT(a_wheel_metre, accept && in_data_i.action == ACT_WHEEL,
    metre_q == $past(metre_q) + 1'b1, "wheel pulse did not advance metre count")

endmodule

### tb/tachometer_speedometer_odometer_tb.sv
// Self-checking testbench for tachometer_speedometer_odometer: timestamped sensor words in,
// one rpm / speed / distance word out per input, checked against an in-bench predictor.
// Depends on tso_pkg and the RTL top level only.
module tachometer_speedometer_odometer_tb;
  import tso_pkg::*;

  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam logic [DATA_W-1:0]    ALL_ONES       = '1;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_t                  in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_t                 out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DATA_W-1:0]    cfg_data_i  = '0;

  tachometer_speedometer_odometer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;
  wire cfg_fire = cfg_valid_i && cfg_ready_o;

  in_t  sensor_word_q[$];
  out_t reading_q[$];

  int unsigned send_idle_pct = 31;
  int unsigned recv_idle_pct = 67;
  int unsigned fail_cnt      = 0;
  int unsigned idle_cycles   = 0;
  int unsigned hold_left     = 0;
  logic        hold_req      = 1'b0;
  logic        hold_ack      = 1'b0;
  logic        in_fired      = 1'b0;
  logic [DATA_W-1:0] gen_clock = '0;

  // Predictor copy of the block's registers and sensor state.
  logic [DATA_W-1:0] stop_tmo    = STOP_TIMEOUT_RST;
  logic [DATA_W-1:0] rpm_k       = RPM_SCALE_RST;
  logic [DATA_W-1:0] speed_k     = SPEED_SCALE_RST;
  logic [DATA_W-1:0] eng_last    = '0;
  logic [DATA_W-1:0] eng_period  = '0;
  logic [DATA_W-1:0] whl_last    = '0;
  logic [DATA_W-1:0] whl_period  = '0;
  logic [DATA_W-1:0] metres      = '0;

  // Apply one sensor word to the state and return the reading it produces.
  function automatic out_t dash_reading(in_t w);
    out_t              r;
    logic [DATA_W-1:0] elapsed;
    case (w.action)
      ACT_ENGINE: begin
        eng_period = w.timestamp_us - eng_last;
        eng_last   = w.timestamp_us;
      end
      ACT_WHEEL: begin
        metres     = metres + 1'b1;
        whl_period = w.timestamp_us - whl_last;
        whl_last   = w.timestamp_us;
      end
      ACT_LOAD: metres = w.odometer_preset;
      default: ;
    endcase
    elapsed          = w.timestamp_us - eng_last;
    r.engine_stopped = elapsed > stop_tmo;
    r.rpm_value      = (r.engine_stopped || eng_period == '0) ? '0 : rpm_k / eng_period;
    r.speed_value    = (whl_period == '0) ? '0 : speed_k / whl_period;
    r.distance_m     = metres;
    return r;
  endfunction

  task automatic check_field(string fname, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] got_v);
    if (exp_v !== got_v) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, fname, exp_v, got_v);
    end
  endtask

  // Monitor: predict on input accept, track register writes, check each result word.
  always @(posedge clk_i) begin
    out_t exp_w;
    if (rst_ni) begin
      in_fired <= in_fire;
      if (in_fire) reading_q.push_back(dash_reading(in_data_i));
      if (cfg_fire) begin
        case (cfg_index_i)
          CFG_STOP_TIMEOUT: stop_tmo = cfg_data_i;
          CFG_RPM_SCALE:    rpm_k    = cfg_data_i;
          CFG_SPEED_SCALE:  speed_k  = cfg_data_i;
          default: ;
        endcase
      end
      if (out_fire) begin
        if (reading_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result word, expected none, got %h", $time, out_data_o);
        end else begin
          exp_w = reading_q.pop_front();
          check_field("rpm_value", exp_w.rpm_value, out_data_o.rpm_value);
          check_field("speed_value", exp_w.speed_value, out_data_o.speed_value);
          check_field("distance_m", exp_w.distance_m, out_data_o.distance_m);
          check_field("engine_stopped", DATA_W'(exp_w.engine_stopped),
                      DATA_W'(out_data_o.engine_stopped));
        end
      end
    end
  end

  // Driver: hold the word until taken, then present the next one or idle.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fired)) begin
      if (sensor_word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data_i  <= sensor_word_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stall, or a long hold-off when requested.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (hold_ack != hold_req) begin
        hold_ack    <= hold_req;
        hold_left   <= HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (in_fire || out_fire || cfg_fire || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL tachometer_speedometer_odometer");
      $finish;
    end
  end

  function automatic in_t mk_word(act_e act, logic [DATA_W-1:0] ts, logic [DATA_W-1:0] preset);
    in_t w;
    w.action          = act;
    w.timestamp_us    = ts;
    w.odometer_preset = preset;
    return w;
  endfunction

  // Random word on a mostly advancing time base, with jumps and repeats.
  function automatic in_t random_word();
    int unsigned       pick;
    act_e              act;
    logic [DATA_W-1:0] preset;
    pick = $urandom_range(99);
    if (pick < 8) gen_clock = $urandom();
    else if (pick < 18) gen_clock = gen_clock;  // repeat: zero period
    else if (pick < 70) gen_clock += $urandom_range(1, 3000);
    else if (pick < 92) gen_clock += $urandom_range(3000, 3000000);
    else gen_clock += $urandom();
    pick = $urandom_range(99);
    if (pick < 35) act = ACT_ENGINE;
    else if (pick < 70) act = ACT_WHEEL;
    else if (pick < 88) act = ACT_REPORT;
    else act = ACT_LOAD;
    preset = ($urandom_range(3) == 0) ? ALL_ONES - $urandom_range(4) : $urandom();
    return mk_word(act, gen_clock, preset);
  endfunction

  // Wait until every queued word is sent and every reading has come back.
  task automatic drain();
    while (sensor_word_q.size() != 0 || in_valid_i || reading_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_batch(int unsigned n, bit long_hold);
    repeat (n) sensor_word_q.push_back(random_word());
    if (long_hold) hold_req = !hold_req;
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset-time periods, timeout edge, wraps, field extremes.
    sensor_word_q.push_back(mk_word(ACT_REPORT, 32'd0, 32'd0));
    sensor_word_q.push_back(mk_word(ACT_ENGINE, 32'd0, 32'd0));
    sensor_word_q.push_back(mk_word(ACT_WHEEL,  32'd0, 32'd0));
    sensor_word_q.push_back(mk_word(ACT_ENGINE, 32'd1000, 32'd0));
    sensor_word_q.push_back(mk_word(ACT_WHEEL,  32'd500, 32'd0));
    sensor_word_q.push_back(mk_word(ACT_REPORT, 32'd1001000, 32'd0));
    sensor_word_q.push_back(mk_word(ACT_REPORT, 32'd1001001, 32'd0));
    sensor_word_q.push_back(mk_word(ACT_LOAD,   32'd1001002, ALL_ONES));
    sensor_word_q.push_back(mk_word(ACT_WHEEL,  32'd600, 32'd0));
    sensor_word_q.push_back(mk_word(ACT_ENGINE, ALL_ONES, 32'd0));
    sensor_word_q.push_back(mk_word(ACT_ENGINE, 32'd5, 32'd0));
    sensor_word_q.push_back(mk_word(ACT_WHEEL,  ALL_ONES, 32'd0));
    sensor_word_q.push_back(mk_word(ACT_LOAD,   32'd5, 32'd0));
    sensor_word_q.push_back(mk_word(ACT_ENGINE, 32'd6, 32'd0));
    sensor_word_q.push_back(mk_word(ACT_WHEEL,  ALL_ONES, ALL_ONES));
    sensor_word_q.push_back(mk_word(ACT_REPORT, ALL_ONES, ALL_ONES));
    sensor_word_q.push_back(mk_word(ACT_LOAD,   32'h5555_5555, 32'hAAAA_AAAA));
    sensor_word_q.push_back(mk_word(ACT_LOAD,   32'hAAAA_AAAA, 32'h5555_5555));
    sensor_word_q.push_back(mk_word(ACT_ENGINE, 32'hAAAA_AAAA, ALL_ONES));
    sensor_word_q.push_back(mk_word(ACT_WHEEL,  32'hAAAA_AAAB, 32'd0));
    drain();

    // Default registers; the receiver blocks for a while to back up the input.
    run_batch(300, 1'b1);

    write_reg(CFG_STOP_TIMEOUT, 32'd0);
    write_reg(CFG_RPM_SCALE, ALL_ONES);
    write_reg(CFG_SPEED_SCALE, 32'd1);
    write_reg(CFG_UNUSED_IDX, 32'h1234_5678);
    sensor_word_q.push_back(mk_word(ACT_ENGINE, gen_clock, 32'd0));
    sensor_word_q.push_back(mk_word(ACT_REPORT, gen_clock + 1, 32'd0));
    run_batch(250, 1'b0);

    send_idle_pct = 67;
    recv_idle_pct = 31;
    write_reg(CFG_STOP_TIMEOUT, ALL_ONES);
    write_reg(CFG_RPM_SCALE, 32'd1);
    write_reg(CFG_SPEED_SCALE, ALL_ONES);
    run_batch(300, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_STOP_TIMEOUT, $urandom_range(500, 200000));
    write_reg(CFG_RPM_SCALE, 32'd0);
    write_reg(CFG_SPEED_SCALE, 32'd0);
    run_batch(150, 1'b0);

    write_reg(CFG_STOP_TIMEOUT, $urandom_range(500, 5000000));
    write_reg(CFG_RPM_SCALE, $urandom());
    write_reg(CFG_SPEED_SCALE, $urandom());
    run_batch(150, 1'b0);

    if (fail_cnt == 0) begin
      $display("PASS tachometer_speedometer_odometer");
    end else begin
      $display("FAIL tachometer_speedometer_odometer");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/tso_pkg.sv
sv/tso_serdiv.sv
sv/tachometer_speedometer_odometer.sv
tb/tachometer_speedometer_odometer_tb.sv
